[src/hbp_pkg.sv]
// ----------------------------------------------------------------------------
// hbp_pkg
// Types, codes and character helpers shared by the request byte parser.
// ----------------------------------------------------------------------------
package hbp_pkg;

  // Item carried on the byte channel
  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_item_t;

  // Item carried on the result channel
  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  byte_class;
    logic [7:0]  byte_out;
    logic        header_begins;
    logic [3:0]  version_major;
    logic [3:0]  version_minor;
    logic [31:0] content_length;
  } out_item_t;

  localparam int unsigned LENGTH_WIDTH_DEF = 32;

  // Item opcodes
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef enum logic [20:0] {
    PH_METHOD_START = 21'd1 << 0,
    PH_METHOD       = 21'd1 << 1,
    PH_URI_START    = 21'd1 << 2,
    PH_URI          = 21'd1 << 3,
    PH_V_H          = 21'd1 << 4,
    PH_V_HT         = 21'd1 << 5,
    PH_V_HTT        = 21'd1 << 6,
    PH_V_HTTP       = 21'd1 << 7,
    PH_V_SLASH      = 21'd1 << 8,
    PH_V_MAJOR      = 21'd1 << 9,
    PH_V_DOT        = 21'd1 << 10,
    PH_V_MINOR      = 21'd1 << 11,
    PH_LINE_CR      = 21'd1 << 12,
    PH_LINE_LF      = 21'd1 << 13,
    PH_HDR_START    = 21'd1 << 14,
    PH_HDR_NAME     = 21'd1 << 15,
    PH_HDR_SPACE    = 21'd1 << 16,
    PH_HDR_VALUE    = 21'd1 << 17,
    PH_BLANK_LF     = 21'd1 << 18,
    PH_BODY         = 21'd1 << 19,
    PH_DONE         = 21'd1 << 20
  } phase_t;

  typedef enum logic [1:0] {
    ST_HEADERS  = 2'd0,
    ST_BODY     = 2'd1,
    ST_COMPLETE = 2'd2,
    ST_ERROR    = 2'd3
  } status_t;

  // Byte labels
  localparam logic [2:0] CLS_NONE      = 3'd0;
  localparam logic [2:0] CLS_METHOD    = 3'd1;
  localparam logic [2:0] CLS_URI       = 3'd2;
  localparam logic [2:0] CLS_HDR_NAME  = 3'd3;
  localparam logic [2:0] CLS_HDR_VALUE = 3'd4;
  localparam logic [2:0] CLS_BODY      = 3'd5;

  // Method prefix tracker
  localparam logic [2:0] M_OTHER = 3'd0;
  localparam logic [2:0] M_G     = 3'd1;
  localparam logic [2:0] M_GE    = 3'd2;
  localparam logic [2:0] M_GET   = 3'd3;
  localparam logic [2:0] M_P     = 3'd4;
  localparam logic [2:0] M_PO    = 3'd5;
  localparam logic [2:0] M_POS   = 3'd6;
  localparam logic [2:0] M_POST  = 3'd7;

  localparam logic [3:0] NAME_LEN  = 4'd14;
  localparam logic [3:0] NAME_FAIL = 4'd15;

  // Characters
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_T     = 8'h54;

  // Per-request control state
  typedef struct packed {
    phase_t     phase;
    status_t    status;
    logic [2:0] method;
    logic [3:0] name_idx;
    logic       hdr_is_len;
    logic       len_seen;
    logic [3:0] major;
    logic [3:0] minor;
  } ctl_state_t;

  localparam ctl_state_t CTL_RESET = '{
    phase:      PH_METHOD_START,
    status:     ST_HEADERS,
    method:     M_OTHER,
    name_idx:   4'd0,
    hdr_is_len: 1'b0,
    len_seen:   1'b0,
    major:      4'd0,
    minor:      4'd0
  };

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_ctl(input logic [7:0] b);
    return b <= 8'd31 || b == CH_DEL;
  endfunction

  function automatic logic [2:0] next_method(input logic [2:0] m, input logic [7:0] b);
    logic [2:0] r;
    r = M_OTHER;
    if (m == M_G && b == CH_E) r = M_GE;
    if (m == M_GE && b == CH_T) r = M_GET;
    if (m == M_P && b == CH_O) r = M_PO;
    if (m == M_PO && b == CH_S) r = M_POS;
    if (m == M_POS && b == CH_T) r = M_POST;
    return r;
  endfunction

  // Lower-case spelling of the length header name
  function automatic logic [7:0] name_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h63; // c
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h6E; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6E; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2D; // -
      4'd8:    c = 8'h6C; // l
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6E; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Advance the case-blind header name match by one byte
  function automatic logic [3:0] match_step(input logic [3:0] idx, input logic [7:0] b);
    logic [7:0] lc;
    lc = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
    if (idx < NAME_LEN && lc == name_char(idx)) return idx + 4'd1;
    return NAME_FAIL;
  endfunction

endpackage

[src/hbp_in_stage.sv]
// ----------------------------------------------------------------------------
// hbp_in_stage
// Input register: captures one item and holds it until the parse step takes it.
// ----------------------------------------------------------------------------
module hbp_in_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_valid,
  output logic             byte_ready,
  input  hbp_pkg::in_item_t byte_item,
  input  logic             advance,
  output logic             stage_valid,
  output hbp_pkg::in_item_t stage_item
);
  import hbp_pkg::*;

  logic     valid;
  in_item_t item;

  // free when empty or when the held item moves on this cycle
  assign byte_ready  = !valid || advance;
  assign stage_valid = valid;
  assign stage_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (byte_ready) begin
      valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ready && byte_valid) begin
      item <= byte_item;
    end
  end

endmodule

[src/hbp_step.sv]
// ----------------------------------------------------------------------------
// hbp_step
// One parse step: next request state and the result item for one byte.
// ----------------------------------------------------------------------------
module hbp_step #(
  parameter int unsigned LENGTH_WIDTH = hbp_pkg::LENGTH_WIDTH_DEF
) (
  input  hbp_pkg::in_item_t   item,
  input  hbp_pkg::ctl_state_t st,
  input  logic [LENGTH_WIDTH-1:0] len_value,
  input  logic [LENGTH_WIDTH-1:0] body_count,
  output hbp_pkg::ctl_state_t st_next,
  output logic [LENGTH_WIDTH-1:0] len_value_next,
  output logic [LENGTH_WIDTH-1:0] body_count_next,
  output hbp_pkg::out_item_t  result
);
  import hbp_pkg::*;

  localparam int unsigned AW = LENGTH_WIDTH + 4;

  logic [7:0]              b;
  logic [3:0]              digit;
  logic [AW-1:0]           acc;
  logic [LENGTH_WIDTH-1:0] len_acc;
  logic [LENGTH_WIDTH-1:0] body_inc;
  logic [2:0]              cls;
  logic                    hb;
  logic [31:0]             cl;

  assign b     = item.data_byte;
  assign digit = 4'(b - CH_ZERO);

  // value * 10 + digit, clamped to the length width
  assign acc     = ({4'd0, len_value} << 3) + ({4'd0, len_value} << 1) + AW'(digit);
  assign len_acc = (|acc[AW-1:LENGTH_WIDTH]) ? '1 : acc[LENGTH_WIDTH-1:0];

  assign body_inc = (&body_count) ? body_count : body_count + 1'b1;

  always_comb begin
    st_next         = st;
    len_value_next  = len_value;
    body_count_next = body_count;
    cls             = CLS_NONE;
    hb              = 1'b0;

    if (item.op == OP_RESTART) begin
      st_next         = CTL_RESET;
      len_value_next  = '0;
      body_count_next = '0;
    end else if (st.status == ST_HEADERS || st.status == ST_BODY) begin
      case (st.phase)
        PH_METHOD_START: begin
          if (!is_letter(b)) begin
            st_next.status = ST_ERROR;
          end else begin
            st_next.method = (b == CH_G) ? M_G : (b == CH_P) ? M_P : M_OTHER;
            st_next.phase  = PH_METHOD;
            cls            = CLS_METHOD;
          end
        end
        PH_METHOD: begin
          if (b == CH_SP || b == CH_TAB) begin
            st_next.phase = PH_URI_START;
          end else if (!is_letter(b)) begin
            st_next.status = ST_ERROR;
          end else begin
            st_next.method = next_method(st.method, b);
            cls            = CLS_METHOD;
          end
        end
        PH_URI_START: begin
          if (is_ctl(b)) begin
            st_next.status = ST_ERROR;
          end else begin
            st_next.phase = PH_URI;
            cls           = CLS_URI;
          end
        end
        PH_URI: begin
          if (b == CH_SP || b == CH_TAB) begin
            st_next.phase = PH_V_H;
          end else if (is_ctl(b)) begin
            st_next.status = ST_ERROR;
          end else begin
            cls = CLS_URI;
          end
        end
        PH_V_H: begin
          if (b != CH_H) st_next.status = ST_ERROR;
          else st_next.phase = PH_V_HT;
        end
        PH_V_HT: begin
          if (b != CH_T) st_next.status = ST_ERROR;
          else st_next.phase = PH_V_HTT;
        end
        PH_V_HTT: begin
          if (b != CH_T) st_next.status = ST_ERROR;
          else st_next.phase = PH_V_HTTP;
        end
        PH_V_HTTP: begin
          if (b != CH_P) st_next.status = ST_ERROR;
          else st_next.phase = PH_V_SLASH;
        end
        PH_V_SLASH: begin
          if (b != CH_SLASH) st_next.status = ST_ERROR;
          else st_next.phase = PH_V_MAJOR;
        end
        PH_V_MAJOR: begin
          if (!is_digit(b)) begin
            st_next.status = ST_ERROR;
          end else begin
            st_next.major = digit;
            st_next.phase = PH_V_DOT;
          end
        end
        PH_V_DOT: begin
          if (b != CH_DOT) st_next.status = ST_ERROR;
          else st_next.phase = PH_V_MINOR;
        end
        PH_V_MINOR: begin
          if (!is_digit(b)) begin
            st_next.status = ST_ERROR;
          end else begin
            st_next.minor = digit;
            st_next.phase = PH_LINE_CR;
          end
        end
        PH_LINE_CR: begin
          if (b != CH_CR) st_next.status = ST_ERROR;
          else st_next.phase = PH_LINE_LF;
        end
        PH_LINE_LF: begin
          if (b != CH_LF) st_next.status = ST_ERROR;
          else st_next.phase = PH_HDR_START;
        end
        PH_HDR_START: begin
          if (b == CH_CR) begin
            st_next.phase = PH_BLANK_LF;
          end else if (is_ctl(b)) begin
            st_next.status = ST_ERROR;
          end else begin
            st_next.name_idx   = match_step(4'd0, b);
            st_next.hdr_is_len = 1'b0;
            st_next.phase      = PH_HDR_NAME;
            cls                = CLS_HDR_NAME;
            hb                 = 1'b1;
          end
        end
        PH_HDR_NAME: begin
          if (is_ctl(b)) begin
            st_next.status = ST_ERROR;
          end else if (b == CH_COLON) begin
            st_next.phase = PH_HDR_SPACE;
            // a repeated length header replaces the earlier value
            if (st.name_idx == NAME_LEN) begin
              st_next.hdr_is_len = 1'b1;
              st_next.len_seen   = 1'b0;
              len_value_next     = '0;
            end
          end else begin
            st_next.name_idx = match_step(st.name_idx, b);
            cls              = CLS_HDR_NAME;
          end
        end
        PH_HDR_SPACE: begin
          if (b != CH_SP) st_next.status = ST_ERROR;
          else st_next.phase = PH_HDR_VALUE;
        end
        PH_HDR_VALUE: begin
          if (b == CH_CR) begin
            st_next.phase      = PH_LINE_LF;
            st_next.hdr_is_len = 1'b0;
          end else if (is_ctl(b)) begin
            st_next.status = ST_ERROR;
          end else begin
            cls = CLS_HDR_VALUE;
            if (st.hdr_is_len) begin
              if (is_digit(b)) begin
                len_value_next   = len_acc;
                st_next.len_seen = 1'b1;
              end else if (!(b == CH_SP && !st.len_seen)) begin
                // any other byte ends the number
                st_next.hdr_is_len = 1'b0;
              end
            end
          end
        end
        PH_BLANK_LF: begin
          // drop extra CR bytes before the final LF
          if (b != CH_CR) begin
            if (b != CH_LF) begin
              st_next.status = ST_ERROR;
            end else if (st.method == M_POST) begin
              st_next.status = ST_BODY;
              st_next.phase  = PH_BODY;
            end else begin
              st_next.status = ST_COMPLETE;
              st_next.phase  = PH_DONE;
            end
          end
        end
        PH_BODY: begin
          cls             = CLS_BODY;
          body_count_next = body_inc;
          if (st.method == M_POST && len_value != '0 && len_value <= body_inc) begin
            st_next.status = ST_COMPLETE;
            st_next.phase  = PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  generate
    if (LENGTH_WIDTH > 32) begin : g_len_sat
      assign cl = (|len_value_next[LENGTH_WIDTH-1:32]) ? '1 : len_value_next[31:0];
    end else begin : g_len_ext
      assign cl = 32'(len_value_next);
    end
  endgenerate

  always_comb begin
    result.status         = st_next.status;
    result.byte_class     = cls;
    result.byte_out       = (cls != CLS_NONE) ? b : 8'd0;
    result.header_begins  = hb;
    result.version_major  = st_next.major;
    result.version_minor  = st_next.minor;
    result.content_length = cl;
  end

endmodule

[src/http_request_byte_parser.sv]
// ----------------------------------------------------------------------------
// http_request_byte_parser
// Byte-at-a-time request parser: request line, headers, length, body.
// ----------------------------------------------------------------------------
//   channel  | valid       | ready       | payload
//   ---------+-------------+-------------+---------------------------------
//   byte     | byte_valid  | byte_ready  | byte_item (op, data_byte)
//   result   | res_valid   | res_ready   | res_item  (status .. length)
//
// One item per cycle sustained while res_ready stays high; each item passes
// through the input register, then the parse step into the result register.
// Reset returns the parser to the start of a request and empties both
// registers. A stalled result holds in its register; the input register
// still takes one more item if it is empty, and backpressure reaches byte_ready.
// ----------------------------------------------------------------------------
module http_request_byte_parser #(
  parameter int unsigned LENGTH_WIDTH = hbp_pkg::LENGTH_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_ready,
  input  hbp_pkg::in_item_t  byte_item,
  output logic               res_valid,
  input  logic               res_ready,
  output hbp_pkg::out_item_t res_item
);
  import hbp_pkg::*;

  logic                    stage_valid;
  in_item_t                stage_item;
  logic                    advance;

  ctl_state_t              st;
  ctl_state_t              st_next;
  logic [LENGTH_WIDTH-1:0] len_value;
  logic [LENGTH_WIDTH-1:0] len_value_next;
  logic [LENGTH_WIDTH-1:0] body_count;
  logic [LENGTH_WIDTH-1:0] body_count_next;
  out_item_t               result;
  logic                    out_valid;
  out_item_t               out_item;

  assign advance = stage_valid && (!out_valid || res_ready);

  hbp_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .byte_item   (byte_item),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  hbp_step #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_step (
    .item            (stage_item),
    .st              (st),
    .len_value       (len_value),
    .body_count      (body_count),
    .st_next         (st_next),
    .len_value_next  (len_value_next),
    .body_count_next (body_count_next),
    .result          (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= CTL_RESET;
      len_value  <= '0;
      body_count <= '0;
      out_valid  <= 1'b0;
    end else if (advance) begin
      st         <= st_next;
      len_value  <= len_value_next;
      body_count <= body_count_next;
      out_valid  <= 1'b1;
    end else if (res_ready) begin
      out_valid  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

  assign res_valid = out_valid;
  assign res_item  = out_item;

  // complete stays complete until a restart is processed
  a_complete_sticky: assert property (@(posedge clk) disable iff (rst)
    (st.status == ST_COMPLETE && !(stage_valid && stage_item.op == OP_RESTART))
      |=> st.status == ST_COMPLETE)
    else $error("complete status left without restart");

  // body phase is only reached by a POST request
  a_body_post: assert property (@(posedge clk) disable iff (rst)
    (st.status == ST_BODY) |-> (st.method == M_POST))
    else $error("body status without POST method");

  a_hdr_begin_class: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_item.header_begins) |-> (res_item.byte_class == CLS_HDR_NAME))
    else $error("header start flagged on a byte that is not a header name");

  // a restart yields a cleared result
  a_restart_result: assert property (@(posedge clk) disable iff (rst)
    (advance && stage_item.op == OP_RESTART)
      |=> (res_valid && res_item.status == ST_HEADERS &&
           res_item.byte_class == CLS_NONE && res_item.content_length == 32'd0))
    else $error("restart did not clear the result");

endmodule
